>>> design/fhas_pkg.sv
// Package for the hashed address set: constants, types and state encodings.
// Used by the top level, fhas_front and fhas_back; depends on nothing.
package fhas_pkg;

  localparam int unsigned TableSizeDefault = 1024;
  localparam logic [63:0] FnvOffset = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime  = 64'h00000100000001b3;
  localparam int unsigned KeyBytes  = 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_INS,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_HASH,
    FS_PUSH
  } front_state_t;

  // One 8-bit FNV-1a round, xor-then-multiply, kept to 64 bits.
  // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

>>> design/fnv_hashed_address_set.sv
// Top level of the FNV-1a hashed address set: front hash, queue, table back end.
// Depends on fhas_pkg, fhas_front, fhas_queue, fhas_back.
//
//  channel  dir  tdata fields (low bit first)            tuser / tlast
//  s_axis   in   opcode[0], address_key[64:1], pad       none
//  m_axis   out  found[0], matched_key[64:1], table_cleared[65], pad  none
//
// An item passes through the hash unit in eight byte rounds, one per cycle.
// Lookups then read the bucket head and read and check each chain entry; inserts write bucket and entry.
// An insert that fills the set first sweeps all TableSize buckets, one per cycle.
// After reset every bucket of the table is cleared before items flow.
// Reset is synchronous, active high; a stalled result holds and blocks the back end.
module fnv_hashed_address_set
  import fhas_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // opcode, address_key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // found, matched_key, table_cleared
);

  localparam int unsigned Qw = $clog2(TableSize) + 65;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [Qw-1:0] f_data, b_data;
  logic [65:0]   res;

  fhas_front #(.TableSize(TableSize)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tdata[0]), .in_key(s_axis_tdata[64:1]),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  fhas_queue #(.Width(Qw)) u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  fhas_back #(.TableSize(TableSize)) u_back (
    .clk, .rst,
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
  );

  assign m_axis_tdata = {6'd0, res};

endmodule

>>> design/fhas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module fhas_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fhas_front.sv
// Front end: accepts items and computes the FNV-1a bucket index one byte per cycle.
// Depends on fhas_pkg; feeds a queue toward the back end.
module fhas_front
  import fhas_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [63:0]                  in_key,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [$clog2(TableSize)+64:0] q_data
);

  localparam int unsigned Aw = $clog2(TableSize);

  front_state_t state, state_next;
  logic [63:0] hash;
  logic [63:0] key;
  logic        op;
  logic [2:0]  byte_idx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: if (in_valid) state_next = FS_HASH;
      FS_HASH: if (byte_idx == 3'(KeyBytes - 1)) state_next = FS_PUSH;
      FS_PUSH: if (q_ready) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == FS_IDLE);
    q_valid  = (state == FS_PUSH);
  end

  // TableSize must be a power of two (the block does not check it), so the modulo is the low bits of the hash
  assign q_data = {hash[Aw-1:0], key, op};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      FS_IDLE: begin
        key      <= in_key;
        op       <= in_op;
        hash     <= FnvOffset;
        byte_idx <= 3'd0;
      end
      FS_HASH: begin
        hash     <= fnv_round(hash, key[8*byte_idx +: 8]);
        byte_idx <= byte_idx + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> design/fhas_queue.sv
// Two-entry FIFO between the hashing front end and the table back end.
// Depends on nothing but its parameter.
module fhas_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);

  logic [Width-1:0] slot [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wptr] <= in_data;
  end

endmodule

>>> design/fhas_back.sv
// Back end: bucket table, entry storage, insert and chain walk, result register.
// Depends on fhas_pkg and fhas_ram.
module fhas_back
  import fhas_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [$clog2(TableSize)+64:0] q_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [65:0]                   res_data
);

  localparam int unsigned Aw = $clog2(TableSize);
  localparam int unsigned Cw = Aw + 1;
  localparam int unsigned Bw = Aw + 1;  // bucket word: {valid, head}
  localparam int unsigned Ew = 64 + Aw + 1;  // entry word: {has_next, next, key}

  back_state_t state, state_next;

  logic          op;
  logic [63:0]   key;
  logic [Aw-1:0] bkt;
  logic [Cw-1:0] count;
  logic [Aw-1:0] clr_idx;
  logic [Cw-1:0] steps;
  logic [Aw-1:0] cur;
  logic          r_found, r_cleared;
  logic [63:0]   r_match;

  // bucket RAM control
  logic          b_we;
  logic [Aw-1:0] b_waddr, b_raddr;
  logic [Bw-1:0] b_wdata, b_rdata;
  // entry RAM control
  logic          e_we;
  logic [Aw-1:0] e_waddr, e_raddr;
  logic [Ew-1:0] e_wdata, e_rdata;

  logic          full;
  logic          chain_live;

  fhas_ram #(.Width(Bw), .Depth(TableSize)) u_bucket (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );
  fhas_ram #(.Width(Ew), .Depth(TableSize)) u_entry (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  assign full       = (count + Cw'(1)) >= Cw'(TableSize);
  // a cleared set reads every bucket as empty
  assign chain_live = b_rdata[Aw] && !r_cleared;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        // after a full-table clear, the pending insert resumes
        if (clr_idx == Aw'(TableSize - 1)) begin
          state_next = r_cleared ? ST_INS : ST_IDLE;
        end
      end
      ST_IDLE:  if (q_valid && !res_valid) begin
        state_next = ST_HEAD;
      end
      ST_HEAD:  begin
        if (op == OP_INSERT) begin
          state_next = full ? ST_CLEAR : ST_INS;
        end else begin
          state_next = b_rdata[Aw] ? ST_READ : ST_DONE;
        end
      end
      ST_INS:   state_next = ST_DONE;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (e_rdata[63:0] == key || !e_rdata[Ew-1] || steps == Cw'(TableSize - 1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs to the RAMs and queue
  always_comb begin
    q_ready = (state == ST_IDLE) && !res_valid;
    b_raddr = bkt;
    b_we    = 1'b0;
    b_waddr = bkt;
    b_wdata = {1'b1, count[Aw-1:0]};
    e_we    = 1'b0;
    e_waddr = count[Aw-1:0];
    e_wdata = {chain_live, b_rdata[Aw-1:0], key};
    e_raddr = cur;
    case (state)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_idx;
        b_wdata = '0;
      end
      ST_IDLE:  b_raddr = q_data[Aw+64:65];
      ST_INS:   begin
        b_we = 1'b1;
        e_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      r_cleared <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + Aw'(1);
          if (clr_idx == Aw'(TableSize - 1)) count <= '0;
        end
        ST_IDLE: if (q_valid && !res_valid) begin
          op        <= q_data[0];
          key       <= q_data[64:1];
          bkt       <= q_data[Aw+64:65];
          r_found   <= 1'b0;
          r_match   <= '0;
          r_cleared <= 1'b0;
        end
        ST_HEAD: begin
          cur   <= b_rdata[Aw-1:0];
          steps <= '0;
          if (op == OP_INSERT && full) begin
            r_cleared <= 1'b1;
            clr_idx   <= '0;
          end
        end
        ST_INS: count <= count + Cw'(1);
        ST_CHECK: begin
          cur   <= e_rdata[Aw+63:64];
          steps <= steps + Cw'(1);
          if (e_rdata[63:0] == key) begin
            r_found <= 1'b1;
            r_match <= key;
          end
        end
        ST_DONE: res_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign res_data = {r_cleared, r_match, r_found};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count < Cw'(TableSize)) else $error("entry count overflow");
  a_insert_no_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op == OP_INSERT) |=> !r_found) else $error("insert reported hit");
  a_lookup_no_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op == OP_LOOKUP) |=> !r_cleared) else $error("lookup cleared");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_data)) else $error("result dropped");
`endif

endmodule
